// ===== design/spq_pkg.sv =====
`timescale 1ns / 1ps
// shared types, constants and helpers for the stable priority event queue
package spq_pkg;

    localparam int CAPACITY = 16;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int AW1      = AW + 1;
    localparam int CW       = $clog2(CAPACITY + 1);

    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [7:0]  priority_req;
        logic [7:0]  status;
        logic [15:0] amount;
        logic [7:0]  system_id;
        logic [7:0]  resource_id;
    } t_in_item;

    typedef struct packed {
        logic        ok;
        logic [7:0]  out_priority;
        logic [7:0]  out_status;
        logic [15:0] out_amount;
        logic [7:0]  out_system_id;
        logic [7:0]  out_resource_id;
        logic [4:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  prio;
        logic [7:0]  stat;
        logic [15:0] amt;
        logic [7:0]  sys;
        logic [7:0]  res;
    } t_rec;

    typedef enum logic [1:0] {
        RES_FAIL,
        RES_PUSH,
        RES_POP
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      rd_prev;
        logic      rd_prev2;
        logic      wr_new;
        logic      wr_move;
        logic      res_load;
        t_res_kind res_kind;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic empty;
        logic full;
        logic pos_zero;
        logic pos_one;
        logic goes_after;
        logic out_free;
    } t_dp_status;

    // physical slot of a logical offset from the head, ring wrap
    function automatic logic [AW-1:0] f_wrap(input logic [AW-1:0] base,
                                             input logic [CW-1:0] off);
        logic [AW:0] s;
        s = {1'b0, base} + AW1'(off);
        if (s >= AW1'(CAPACITY)) begin
            s = s - AW1'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

endpackage

// ===== design/spq_ctrl.sv =====
`timescale 1ns / 1ps
// sequencing state machine for the stable priority event queue
module spq_ctrl import spq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd,
    output logic       o_in_stall
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP_RD,
        S_RESULT
    } t_state;

    t_state    r_state, n_state;
    t_res_kind r_res_kind, n_res_kind;

    always_comb begin
        n_state    = r_state;
        n_res_kind = r_res_kind;
        o_cmd      = '0;
        o_cmd.res_kind = r_res_kind;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.kind == KIND_POP) begin
                    if (i_status.empty) begin
                        n_res_kind = RES_FAIL;
                        n_state    = S_RESULT;
                    end else begin
                        n_state = S_POP_RD;
                    end
                end else begin
                    if (i_status.full) begin
                        n_res_kind = RES_FAIL;
                        n_state    = S_RESULT;
                    end else begin
                        n_state = S_PUSH_RD;
                    end
                end
            end
            S_PUSH_RD: begin
                if (i_status.pos_zero) begin
                    o_cmd.wr_new = 1'b1;
                    n_res_kind   = RES_PUSH;
                    n_state      = S_RESULT;
                end else begin
                    o_cmd.rd_prev = 1'b1;
                    n_state       = S_PUSH_CMP;
                end
            end
            S_PUSH_CMP: begin
                if (i_status.goes_after) begin
                    o_cmd.wr_new = 1'b1;
                    n_res_kind   = RES_PUSH;
                    n_state      = S_RESULT;
                end else begin
                    o_cmd.wr_move = 1'b1;
                    if (i_status.pos_one) begin
                        n_state = S_PUSH_RD;
                    end else begin
                        o_cmd.rd_prev2 = 1'b1;
                    end
                end
            end
            S_POP_RD: begin
                // head offset is zero, same as pos minus one is not used here
                n_res_kind = RES_POP;
                n_state    = S_RESULT;
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_res_kind <= RES_FAIL;
        end else begin
            r_state    <= n_state;
            r_res_kind <= n_res_kind;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== design/spq_dp.sv =====
`timescale 1ns / 1ps
// entry store, ring pointers and result register for the stable priority event queue
module spq_dp import spq_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_in_item   i_in_data,
    input  t_dp_cmd    i_cmd,
    output t_dp_status o_status,
    input  logic       i_out_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data
);

    t_rec           mem [CAPACITY];
    t_rec           r_rdata;
    t_rec           r_rec;
    logic           r_kind;
    logic [AW-1:0]  r_head;
    logic [CW-1:0]  r_count;
    logic [CW-1:0]  r_pos;
    logic           r_out_valid;
    t_out_item      r_out;

    logic [CW-1:0]  pos_m1;
    logic [CW-1:0]  pos_m2;
    logic [AW-1:0]  waddr;
    logic [AW-1:0]  raddr;
    logic           rd_en;
    logic           wr_en;
    t_rec           wdata;
    logic [CW-1:0]  n_count;
    t_out_item      res;

    assign pos_m1 = r_pos - CW'(1);
    assign pos_m2 = r_pos - CW'(2);
    assign waddr  = f_wrap(r_head, r_pos);
    assign wr_en  = i_cmd.wr_new | i_cmd.wr_move;
    assign wdata  = i_cmd.wr_move ? r_rdata : r_rec;

    // pop reads the head slot, a push step reads the slot before the hole
    always_comb begin
        rd_en = 1'b1;
        raddr = r_head;
        if (i_cmd.rd_prev) begin
            raddr = f_wrap(r_head, pos_m1);
        end else if (i_cmd.rd_prev2) begin
            raddr = f_wrap(r_head, pos_m2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[waddr] <= wdata;
        end
        if (rd_en) begin
            r_rdata <= mem[raddr];
        end
    end

    always_comb begin
        res           = '0;
        n_count       = r_count;
        case (i_cmd.res_kind)
            RES_PUSH: begin
                n_count = r_count + CW'(1);
                res.ok  = 1'b1;
            end
            RES_POP: begin
                n_count             = r_count - CW'(1);
                res.ok              = 1'b1;
                res.out_priority    = r_rdata.prio;
                res.out_status      = r_rdata.stat;
                res.out_amount      = r_rdata.amt;
                res.out_system_id   = r_rdata.sys;
                res.out_resource_id = r_rdata.res;
            end
            default: begin
                n_count = r_count;
            end
        endcase
        res.occupancy = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind     <= i_in_data.kind;
            r_rec.prio <= i_in_data.priority_req;
            r_rec.stat <= i_in_data.status;
            r_rec.amt  <= i_in_data.amount;
            r_rec.sys  <= i_in_data.system_id;
            r_rec.res  <= i_in_data.resource_id;
            r_pos      <= r_count;
        end else if (i_cmd.wr_move) begin
            r_pos <= pos_m1;
        end
        if (i_cmd.res_load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.res_load) begin
                r_count <= n_count;
                if (i_cmd.res_kind == RES_POP) begin
                    r_head <= f_wrap(r_head, CW'(1));
                end
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.kind       = r_kind;
    assign o_status.empty      = (r_count == '0);
    assign o_status.full       = (r_count >= CW'(CAPACITY));
    assign o_status.pos_zero   = (r_pos == '0);
    assign o_status.pos_one    = (r_pos == CW'(1));
    assign o_status.goes_after = (r_rdata.prio >= r_rec.prio);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== design/stable_priority_event_queue.sv =====
`timescale 1ns / 1ps
// top level of the stable priority event queue
// Holds up to CAPACITY event records in a ring store, highest priority at the
// head; equal priorities leave in arrival order. One item is worked at a time.
// From acceptance, an item is decoded; a refused push or a pop on an empty
// queue then goes straight to the result, a pop first reads the head slot, and
// a push into an empty queue writes the new entry. Any other push walks back
// from the tail one entry per cycle, reading the next entry while the last one
// is moved, and writes the new entry behind the first one of equal or higher
// priority. The next item is accepted in the cycle after the result is in the
// output register, and that register is freed as soon as the result is taken.
module stable_priority_event_queue import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    spq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/spq_result_checker.sv =====
`timescale 1ns / 1ps
// watches both channels of the event queue, predicts every result and compares it
module spq_result_checker import spq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int MAX_REPORTS = 40;

    t_rec      event_store [CAPACITY];
    int        stored_count = 0;
    t_out_item expected_results [$];
    int        mismatches = 0;
    int        pending_now = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_now;

    function automatic t_out_item apply_queue_op(input t_in_item item);
        t_out_item res;
        int        pos;
        res = '0;
        if (item.kind == KIND_PUSH) begin
            if (stored_count < CAPACITY) begin
                pos = 0;
                while (pos < stored_count && event_store[pos].prio >= item.priority_req) begin
                    pos++;
                end
                for (int k = stored_count; k > pos; k--) begin
                    event_store[k] = event_store[k - 1];
                end
                event_store[pos].prio = item.priority_req;
                event_store[pos].stat = item.status;
                event_store[pos].amt  = item.amount;
                event_store[pos].sys  = item.system_id;
                event_store[pos].res  = item.resource_id;
                stored_count++;
                res.ok = 1'b1;
            end
        end else if (stored_count > 0) begin
            res.ok              = 1'b1;
            res.out_priority    = event_store[0].prio;
            res.out_status      = event_store[0].stat;
            res.out_amount      = event_store[0].amt;
            res.out_system_id   = event_store[0].sys;
            res.out_resource_id = event_store[0].res;
            for (int k = 1; k < stored_count; k++) begin
                event_store[k - 1] = event_store[k];
            end
            stored_count--;
        end
        res.occupancy = 5'(stored_count);
        return res;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want_val,
                               input logic [15:0] got_val);
        if (got_val !== want_val) begin
            if (mismatches < MAX_REPORTS) begin
                $display("%0t: %s expected %0h got %0h", $time, name, want_val, got_val);
            end
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            stored_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    if (mismatches < MAX_REPORTS) begin
                        $display("%0t: result expected none got %h", $time, i_out_data);
                    end
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("ok", 16'(want.ok), 16'(i_out_data.ok));
                    check_field("out_priority", 16'(want.out_priority),
                                16'(i_out_data.out_priority));
                    check_field("out_status", 16'(want.out_status), 16'(i_out_data.out_status));
                    check_field("out_amount", want.out_amount, i_out_data.out_amount);
                    check_field("out_system_id", 16'(want.out_system_id),
                                16'(i_out_data.out_system_id));
                    check_field("out_resource_id", 16'(want.out_resource_id),
                                16'(i_out_data.out_resource_id));
                    check_field("occupancy", 16'(want.occupancy), 16'(i_out_data.occupancy));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                expected_results.push_back(apply_queue_op(i_in_data));
            end
        end
        pending_now <= expected_results.size();
    end

endmodule

// ===== tb/stable_priority_event_queue_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the stable priority event queue: stimulus, flow control and verdict
module stable_priority_event_queue_tb;
    import spq_pkg::*;

    localparam int RANDOM_ITEMS = 750;
    localparam int BLOCK_LEN    = 30;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 40;
    localparam int LONG_HOLD    = 400;

    typedef enum int {PRIO_ANY, PRIO_FEW, PRIO_EDGE} t_prio_mix;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    bit        tx_quiet = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    stable_priority_event_queue dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    spq_result_checker result_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic t_in_item push_item(input logic [7:0] prio, input logic [7:0] stat,
                                           input logic [15:0] amt, input logic [7:0] sys,
                                           input logic [7:0] res);
        t_in_item item;
        item              = '0;
        item.kind         = KIND_PUSH;
        item.priority_req = prio;
        item.status       = stat;
        item.amount       = amt;
        item.system_id    = sys;
        item.resource_id  = res;
        return item;
    endfunction

    function automatic t_in_item pop_item();
        t_in_item item;
        item      = '0;
        item.kind = KIND_POP;
        return item;
    endfunction

    function automatic t_in_item random_item(input int push_pct, input t_prio_mix mix);
        t_in_item item;
        item.kind        = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_POP;
        item.status      = 8'($urandom);
        item.amount      = 16'($urandom);
        item.system_id   = 8'($urandom);
        item.resource_id = 8'($urandom);
        case (mix)
            PRIO_ANY: begin
                item.priority_req = 8'($urandom);
            end
            PRIO_FEW: begin
                item.priority_req = 8'($urandom_range(0, 3));
            end
            default: begin
                item.priority_req = 8'($urandom_range(0, 1));
                if ($urandom_range(0, 1) == 1) begin
                    item.priority_req = ~item.priority_req;
                end
            end
        endcase
        return item;
    endfunction

    task automatic send_item(input t_in_item item);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= item;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : result_sink
        int  hold;
        int  taken;
        bit  rx_quiet;
        taken    = 0;
        rx_quiet = 1'b0;
        out_stall <= 1'b1;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (taken % 60 == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (taken == 250 || taken == 600) begin
                hold = LONG_HOLD;
            end else begin
                hold = rx_quiet ? 0 : $urandom_range(0, 5);
            end
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            taken++;
        end
    end

    initial begin : stimulus
        logic [7:0] fill_prio [12];
        int         push_pct;
        t_prio_mix  mix;
        fill_prio = '{8'd128, 8'd128, 8'd1, 8'd254, 8'd128, 8'd0,
                      8'd255, 8'd64, 8'd64, 8'd200, 8'd1, 8'd127};
        push_pct  = 50;
        mix       = PRIO_ANY;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pop, extremes, equal priorities, fill up, refused push
        send_item(pop_item());
        send_item(push_item(8'h00, 8'h00, 16'h0000, 8'h00, 8'h00));
        send_item(push_item(8'hFF, 8'hFF, 16'hFFFF, 8'hFF, 8'hFF));
        send_item(push_item(8'hFF, 8'h5A, 16'hA5A5, 8'h01, 8'h02));
        send_item(push_item(8'h00, 8'hA5, 16'h5A5A, 8'h03, 8'h04));
        foreach (fill_prio[k]) begin
            send_item(push_item(fill_prio[k], 8'(k), 16'(k * 4099), 8'(k + 16), 8'(255 - k)));
        end
        send_item(push_item(8'h80, 8'h11, 16'h2222, 8'h33, 8'h44));
        repeat (3) send_item(pop_item());
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BLOCK_LEN == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 20;
                    1: push_pct = 50;
                    default: push_pct = 80;
                endcase
                mix      = t_prio_mix'($urandom_range(0, 2));
                tx_quiet = ($urandom_range(0, 3) == 0);
            end
            if (n == RANDOM_ITEMS / 2) begin
                wait_drained();
            end
            send_item(random_item(push_pct, mix));
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
